/* rtl/assert_macros.svh */
// Assertion helpers for the RTL file that checks its own logic.
// Every check runs on the rising edge of i_clk and is off while reset is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The property must hold at every active clock edge.
`define ASSERT_CLK(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// The expression must never be true.
`define ASSERT_NEVER(lbl, expr, msg) \
    `ASSERT_CLK(lbl, !(expr), msg)

`endif

/* rtl/dspt_pkg.sv */
`default_nettype none

package dspt_pkg;

    // Fixed field widths of the item interface.
    localparam int DATA_W   = 24;
    localparam int SEL_W    = 4;
    localparam int CH_SLOTS = 4;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 4;

    // Defaults for the top-level parameters.
    localparam int COUNTER_BITS_DEF = 24;
    localparam int NUM_CHANNELS_DEF = 4;

    // Item actions.
    typedef enum logic [1:0] {
        ACT_TICK  = 2'd0,
        ACT_WRITE = 2'd1,
        ACT_READ  = 2'd2,
        ACT_NONE  = 2'd3
    } t_action;

    // Register selector codes.
    localparam logic [SEL_W-1:0] REG_PERIOD     = 4'd0;
    localparam logic [SEL_W-1:0] REG_PERIOD_BUF = 4'd1;
    localparam logic [SEL_W-1:0] REG_CMP0       = 4'd2;
    localparam logic [SEL_W-1:0] REG_CMP3       = 4'd5;
    localparam logic [SEL_W-1:0] REG_CMP_BUF0   = 4'd6;
    localparam logic [SEL_W-1:0] REG_CMP_BUF3   = 4'd9;
    localparam logic [SEL_W-1:0] REG_LOCK_SET   = 4'd10;
    localparam logic [SEL_W-1:0] REG_LOCK_CLR   = 4'd11;
    localparam logic [SEL_W-1:0] REG_STATUS     = 4'd12;
    localparam logic [SEL_W-1:0] REG_IRQ_FLAGS  = 4'd13;
    localparam logic [SEL_W-1:0] REG_COUNT      = 4'd14;

    // Status word bit positions.
    localparam int STAT_PER_VLD_BIT = 4;
    localparam int STAT_FAULT_BIT   = 5;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_ENABLE       = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_INVERT_MASK  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_FAULT_ENABLE = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_FAULT_LEVEL  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_OVF_IRQ_EN   = 3'd4;

    typedef struct packed {
        t_action           action;
        logic [SEL_W-1:0]  reg_select;
        logic [DATA_W-1:0] write_data;
        logic              fault_event;
    } t_in_item;

    typedef struct packed {
        logic [DATA_W-1:0]   read_data;
        logic [CH_SLOTS-1:0] pwm_out;
        logic                irq;
        logic                fault_active;
    } t_out_item;

    // Configuration seen by the timer core.
    typedef struct packed {
        logic                enable;
        logic [CH_SLOTS-1:0] invert_mask;
        logic                fault_enable;
        logic                fault_level;
        logic                ovf_irq_en;
    } t_cfg;

endpackage

`default_nettype wire

/* rtl/dspt_cfg_regs.sv */
`default_nettype none

module dspt_cfg_regs (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_cfg_valid,
    input  wire logic [dspt_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [dspt_pkg::CFG_DATA_W-1:0] i_cfg_data,
    output      logic                           o_cfg_ready,
    output      dspt_pkg::t_cfg                 o_cfg
);
    import dspt_pkg::*;

    t_cfg r_cfg;

    // Writes are taken in any cycle.
    assign o_cfg_ready = 1'b1;
    assign o_cfg       = r_cfg;

    // Register file; indexes beyond the list are dropped.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.enable       <= 1'b0;
            r_cfg.invert_mask  <= '0;
            r_cfg.fault_enable <= 1'b1;
            r_cfg.fault_level  <= 1'b0;
            r_cfg.ovf_irq_en   <= 1'b1;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_ENABLE:       r_cfg.enable       <= i_cfg_data[0];
                CFG_INVERT_MASK:  r_cfg.invert_mask  <= i_cfg_data[CH_SLOTS-1:0];
                CFG_FAULT_ENABLE: r_cfg.fault_enable <= i_cfg_data[0];
                CFG_FAULT_LEVEL:  r_cfg.fault_level  <= i_cfg_data[0];
                CFG_OVF_IRQ_EN:   r_cfg.ovf_irq_en   <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

endmodule

`default_nettype wire

/* rtl/dspt_core.sv */
`default_nettype none

module dspt_core #(
    parameter int CNT_W  = dspt_pkg::COUNTER_BITS_DEF,
    parameter int NUM_CH = dspt_pkg::NUM_CHANNELS_DEF
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_accept,
    input  wire dspt_pkg::t_in_item  i_item,
    input  wire dspt_pkg::t_cfg      i_cfg,
    output      dspt_pkg::t_out_item o_result
);
    import dspt_pkg::*;

    localparam int ACT_CH = (NUM_CH < CH_SLOTS) ? NUM_CH : CH_SLOTS;
    localparam int WIDE_W = (CNT_W > DATA_W) ? CNT_W : DATA_W;
    localparam logic [CH_SLOTS-1:0] CH_MASK = CH_SLOTS'({ACT_CH{1'b1}});

    // Timer state.
    logic [CNT_W-1:0]  r_cnt,  n_cnt;
    logic              r_down, n_down;
    logic [CNT_W-1:0]  r_per,  n_per;
    logic [CNT_W-1:0]  r_per_buf, n_per_buf;
    logic [CNT_W-1:0]  r_cmp [ACT_CH];
    logic [CNT_W-1:0]  n_cmp [ACT_CH];
    logic [CNT_W-1:0]  r_cmp_buf [ACT_CH];
    logic [CNT_W-1:0]  n_cmp_buf [ACT_CH];
    logic [ACT_CH-1:0] r_cmp_vld, n_cmp_vld;
    logic              r_per_vld, n_per_vld;
    logic              r_lock, n_lock;
    logic              r_ovf, n_ovf;
    logic              r_fault, n_fault;

    logic [WIDE_W-1:0]   wr_wide;
    logic [CNT_W-1:0]    wr_val;
    logic [CNT_W-1:0]    cnt_inc;
    logic [CNT_W-1:0]    cnt_dec;
    logic [WIDE_W-1:0]   rd_wide;
    logic [CH_SLOTS-1:0] vld_pad;
    logic [CH_SLOTS-1:0] pwm;

    // Write data cut or widened to the counter width.
    assign wr_wide = WIDE_W'(i_item.write_data);
    assign wr_val  = wr_wide[CNT_W-1:0];
    assign cnt_inc = r_cnt + 1'b1;
    assign cnt_dec = (r_cnt != '0) ? (r_cnt - 1'b1) : r_cnt;

    // Next state for one item.
    always_comb begin
        n_cnt     = r_cnt;
        n_down    = r_down;
        n_per     = r_per;
        n_per_buf = r_per_buf;
        n_cmp     = r_cmp;
        n_cmp_buf = r_cmp_buf;
        n_cmp_vld = r_cmp_vld;
        n_per_vld = r_per_vld;
        n_lock    = r_lock;
        n_ovf     = r_ovf;
        n_fault   = r_fault;
        case (i_item.action)
            ACT_TICK: begin
                if (i_item.fault_event && i_cfg.fault_enable) begin
                    n_fault = 1'b1;
                end
                if (!i_cfg.enable) begin
                    n_cnt  = '0;
                    n_down = 1'b0;
                end else if (!r_down) begin
                    // Up slope; the top is taken when the count meets the period.
                    if (r_cnt < r_per) begin
                        n_cnt = cnt_inc;
                        if (cnt_inc == r_per) begin
                            n_ovf  = 1'b1;
                            n_down = 1'b1;
                        end
                    end else begin
                        n_ovf  = 1'b1;
                        n_down = 1'b1;
                        n_cnt  = cnt_dec;
                    end
                end else begin
                    // Down slope; at the bottom load valid buffers unless locked.
                    n_cnt = cnt_dec;
                    if (cnt_dec == '0) begin
                        n_down = 1'b0;
                        if (!r_lock) begin
                            for (int c = 0; c < ACT_CH; c++) begin
                                if (r_cmp_vld[c]) begin
                                    n_cmp[c]     = r_cmp_buf[c];
                                    n_cmp_vld[c] = 1'b0;
                                end
                            end
                            if (r_per_vld) begin
                                n_per     = r_per_buf;
                                n_per_vld = 1'b0;
                            end
                        end
                    end
                end
            end
            ACT_WRITE: begin
                if (i_item.reg_select == REG_PERIOD) begin
                    n_per = wr_val;
                end
                if (i_item.reg_select == REG_PERIOD_BUF) begin
                    n_per_buf = wr_val;
                    n_per_vld = 1'b1;
                end
                for (int c = 0; c < ACT_CH; c++) begin
                    if (i_item.reg_select == REG_CMP0 + SEL_W'(c)) begin
                        n_cmp[c] = wr_val;
                    end
                    if (i_item.reg_select == REG_CMP_BUF0 + SEL_W'(c)) begin
                        n_cmp_buf[c] = wr_val;
                        n_cmp_vld[c] = 1'b1;
                    end
                end
                if (i_item.reg_select == REG_LOCK_SET) begin
                    n_lock = 1'b1;
                end
                if (i_item.reg_select == REG_LOCK_CLR) begin
                    n_lock = 1'b0;
                end
                // Status and flag writes clear the bits written as one.
                if (i_item.reg_select == REG_STATUS) begin
                    n_cmp_vld = r_cmp_vld & ~i_item.write_data[ACT_CH-1:0];
                    if (i_item.write_data[STAT_PER_VLD_BIT]) begin
                        n_per_vld = 1'b0;
                    end
                    if (i_item.write_data[STAT_FAULT_BIT]) begin
                        n_fault = 1'b0;
                    end
                end
                if (i_item.reg_select == REG_IRQ_FLAGS && i_item.write_data[0]) begin
                    n_ovf = 1'b0;
                end
                if (i_item.reg_select == REG_COUNT) begin
                    n_cnt = wr_val;
                end
            end
            default: ;
        endcase
    end

    // Read mux; a read changes no state.
    assign vld_pad = CH_SLOTS'(r_cmp_vld);

    always_comb begin
        rd_wide = '0;
        if (i_item.action == ACT_READ) begin
            case (i_item.reg_select) inside
                REG_PERIOD:                  rd_wide = WIDE_W'(r_per);
                REG_PERIOD_BUF:              rd_wide = WIDE_W'(r_per_buf);
                [REG_CMP0:REG_CMP3]: begin
                    for (int c = 0; c < ACT_CH; c++) begin
                        if (i_item.reg_select == REG_CMP0 + SEL_W'(c)) begin
                            rd_wide = WIDE_W'(r_cmp[c]);
                        end
                    end
                end
                [REG_CMP_BUF0:REG_CMP_BUF3]: begin
                    for (int c = 0; c < ACT_CH; c++) begin
                        if (i_item.reg_select == REG_CMP_BUF0 + SEL_W'(c)) begin
                            rd_wide = WIDE_W'(r_cmp_buf[c]);
                        end
                    end
                end
                REG_LOCK_SET, REG_LOCK_CLR:  rd_wide = WIDE_W'(r_lock);
                REG_STATUS:                  rd_wide = WIDE_W'({r_fault, r_per_vld, vld_pad});
                REG_IRQ_FLAGS:               rd_wide = WIDE_W'(r_ovf);
                REG_COUNT:                   rd_wide = WIDE_W'(r_cnt);
                default:                     rd_wide = '0;
            endcase
        end
    end

    // Channel levels from the state after the item.
    always_comb begin
        pwm = '0;
        if (!i_cfg.enable) begin
            pwm = '0;
        end else if (n_fault) begin
            pwm = i_cfg.fault_level ? CH_MASK : '0;
        end else begin
            for (int c = 0; c < ACT_CH; c++) begin
                pwm[c] = (n_cnt < n_cmp[c]) ^ i_cfg.invert_mask[c];
            end
        end
    end

    assign o_result.read_data    = rd_wide[DATA_W-1:0];
    assign o_result.pwm_out      = pwm;
    assign o_result.irq          = n_ovf & i_cfg.ovf_irq_en;
    assign o_result.fault_active = n_fault;

    // State registers, updated on each transfer.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt     <= '0;
            r_down    <= 1'b0;
            r_per     <= '1;
            r_per_buf <= '1;
            for (int c = 0; c < ACT_CH; c++) begin
                r_cmp[c]     <= '0;
                r_cmp_buf[c] <= '0;
            end
            r_cmp_vld <= '0;
            r_per_vld <= 1'b0;
            r_lock    <= 1'b0;
            r_ovf     <= 1'b0;
            r_fault   <= 1'b0;
        end else if (i_accept) begin
            r_cnt     <= n_cnt;
            r_down    <= n_down;
            r_per     <= n_per;
            r_per_buf <= n_per_buf;
            r_cmp     <= n_cmp;
            r_cmp_buf <= n_cmp_buf;
            r_cmp_vld <= n_cmp_vld;
            r_per_vld <= n_per_vld;
            r_lock    <= n_lock;
            r_ovf     <= n_ovf;
            r_fault   <= n_fault;
        end
    end

endmodule

`default_nettype wire

/* rtl/dspt_out_buf.sv */
`default_nettype none

module dspt_out_buf (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_push,
    input  wire dspt_pkg::t_out_item i_data,
    output      logic                o_ready,
    output      logic                o_valid,
    input  wire logic                i_out_ready,
    output      dspt_pkg::t_out_item o_data
);
    import dspt_pkg::*;

    t_out_item r_main;
    t_out_item r_skid;
    logic      r_main_vld;
    logic      r_skid_vld;
    logic      pop;

    // The skid entry holds a result that arrived while the output stalled.
    assign o_ready = !r_skid_vld;
    assign o_valid = r_main_vld;
    assign o_data  = r_main;
    assign pop     = r_main_vld && i_out_ready;

    // Valid flags.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_main_vld <= 1'b0;
            r_skid_vld <= 1'b0;
        end else if (pop || !r_main_vld) begin
            r_main_vld <= r_skid_vld || i_push;
            r_skid_vld <= 1'b0;
        end else if (i_push) begin
            r_skid_vld <= 1'b1;
        end
    end

    // Payload entries.
    always_ff @(posedge i_clk) begin
        if (pop || !r_main_vld) begin
            r_main <= r_skid_vld ? r_skid : i_data;
        end else if (i_push) begin
            r_skid <= i_data;
        end
    end

endmodule

`default_nettype wire

/* rtl/dual_slope_pwm_timer_unit.sv */
// Channel   Handshake                  Payload
// in        i_in_valid / o_in_ready    i_in_item  (action, select, data, fault event)
// out       o_out_valid / i_out_ready  o_out_item (read data, levels, irq, fault)
// cfg       i_cfg_valid / o_cfg_ready  i_cfg_index, i_cfg_data
//
// Each item is processed in the cycle it is transferred; its result is
// registered in the output buffer. One item per cycle is sustained while
// the consumer takes results; a two-entry output buffer lets one more item
// in while a result waits for the consumer, after which input stalls.
// Reset is synchronous and active low; there is no clearing pass.
// The configuration port is always ready.
`default_nettype none

module dual_slope_pwm_timer_unit #(
    parameter int COUNTER_BITS = dspt_pkg::COUNTER_BITS_DEF,
    parameter int NUM_CHANNELS = dspt_pkg::NUM_CHANNELS_DEF
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_in_valid,
    output      logic                            o_in_ready,
    input  wire dspt_pkg::t_in_item              i_in_item,
    output      logic                            o_out_valid,
    input  wire logic                            i_out_ready,
    output      dspt_pkg::t_out_item             o_out_item,
    input  wire logic                            i_cfg_valid,
    output      logic                            o_cfg_ready,
    input  wire logic [dspt_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [dspt_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import dspt_pkg::*;

    `include "assert_macros.svh"

    localparam int ACT_CH = (NUM_CHANNELS < CH_SLOTS) ? NUM_CHANNELS : CH_SLOTS;
    localparam logic [CH_SLOTS-1:0] CH_MASK = CH_SLOTS'({ACT_CH{1'b1}});

    t_cfg      w_cfg;
    t_out_item w_result;
    logic      w_accept;

    assign w_accept = i_in_valid && o_in_ready;

    // Configuration registers.
    dspt_cfg_regs u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg_ready (o_cfg_ready),
        .o_cfg       (w_cfg)
    );

    // Counter, buffered registers and channel compare.
    dspt_core #(
        .CNT_W  (COUNTER_BITS),
        .NUM_CH (NUM_CHANNELS)
    ) u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (w_accept),
        .i_item   (i_in_item),
        .i_cfg    (w_cfg),
        .o_result (w_result)
    );

    // Result register with skid entry.
    dspt_out_buf u_out (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (w_accept),
        .i_data      (w_result),
        .o_ready     (o_in_ready),
        .o_valid     (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_data      (o_out_item)
    );

    // Input only stalls when both output entries are occupied.
    `ASSERT_CLK(a_stall_needs_result, !o_in_ready |-> o_out_valid, "input stalled with no result pending")
    // A transfer in always leaves a result on the output next cycle.
    `ASSERT_CLK(a_transfer_gives_result, w_accept |=> o_out_valid, "transfer produced no result")
    // Channels that are not present never drive a high level.
    `ASSERT_NEVER(a_absent_channels_low, o_out_valid && ((o_out_item.pwm_out & ~CH_MASK) != '0), "absent channel driven high")

endmodule

`default_nettype wire

/* tb/sv/tb_dual_slope_pwm_timer_unit.sv */
module tb_dual_slope_pwm_timer_unit;

    import dspt_pkg::*;

    // Selector code that no register answers to.
    localparam logic [SEL_W-1:0] SEL_UNUSED = 4'd15;
    localparam int CYCLE_LIMIT = 200000;
    localparam int DRAIN_CYCLES = 4;
    localparam int SEGMENT_ITEMS = 225;
    localparam int NUM_SEGMENTS = 8;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    wire in_ready;
    t_in_item in_item = '0;
    wire out_valid;
    logic out_ready = 1'b0;
    t_out_item out_item;
    logic cfg_valid = 1'b0;
    wire cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int mismatch_count = 0;
    int cycle_count = 0;

    // Results still owed by the timer, oldest first.
    t_out_item timer_outputs_due[$];

    // Predicted timer state and configuration.
    t_cfg tm_cfg = '{1'b0, 4'h0, 1'b1, 1'b0, 1'b1};
    logic [DATA_W-1:0] tm_count = '0;
    logic tm_down = 1'b0;
    logic [DATA_W-1:0] tm_period = '1;
    logic [DATA_W-1:0] tm_period_buf = '1;
    logic [DATA_W-1:0] tm_cmp [CH_SLOTS] = '{default: '0};
    logic [DATA_W-1:0] tm_cmp_buf [CH_SLOTS] = '{default: '0};
    logic [STAT_PER_VLD_BIT:0] tm_buf_valid = '0;
    logic tm_locked = 1'b0;
    logic tm_overflow = 1'b0;
    logic tm_fault = 1'b0;

    dual_slope_pwm_timer_unit i_dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_item   (in_item),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_item  (out_item),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    always begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
    end

    // The receiver stalls at random according to the current phase.
    always @(posedge clk) begin
        out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // Apply one item to the predicted timer and return the result it causes.
    function automatic t_out_item advance_timer(input t_in_item it);
        t_out_item res;
        logic [DATA_W-1:0] rd;
        logic [SEL_W-1:0] sel;
        logic [DATA_W-1:0] data;
        int ch;
        rd = '0;
        sel = it.reg_select;
        data = it.write_data;
        if (it.action == ACT_TICK) begin
            if (it.fault_event && tm_cfg.fault_enable) begin
                tm_fault = 1'b1;
            end
            if (!tm_cfg.enable) begin
                tm_count = '0;
                tm_down = 1'b0;
            end else if (!tm_down) begin
                // Rising slope; the top is taken at once if already reached.
                if (tm_count < tm_period) begin
                    tm_count = tm_count + 1'b1;
                    if (tm_count == tm_period) begin
                        tm_overflow = 1'b1;
                        tm_down = 1'b1;
                    end
                end else begin
                    tm_overflow = 1'b1;
                    tm_down = 1'b1;
                    if (tm_count != '0) begin
                        tm_count = tm_count - 1'b1;
                    end
                end
            end else begin
                // Falling slope; at the bottom the buffers load unless locked.
                if (tm_count != '0) begin
                    tm_count = tm_count - 1'b1;
                end
                if (tm_count == '0) begin
                    if (!tm_locked) begin
                        for (ch = 0; ch < CH_SLOTS; ch++) begin
                            if (tm_buf_valid[ch]) begin
                                tm_cmp[ch] = tm_cmp_buf[ch];
                                tm_buf_valid[ch] = 1'b0;
                            end
                        end
                        if (tm_buf_valid[STAT_PER_VLD_BIT]) begin
                            tm_period = tm_period_buf;
                            tm_buf_valid[STAT_PER_VLD_BIT] = 1'b0;
                        end
                    end
                    tm_down = 1'b0;
                end
            end
        end else if (it.action == ACT_WRITE) begin
            if (sel == REG_PERIOD) begin
                tm_period = data;
            end else if (sel == REG_PERIOD_BUF) begin
                tm_period_buf = data;
                tm_buf_valid[STAT_PER_VLD_BIT] = 1'b1;
            end else if (sel >= REG_CMP0 && sel <= REG_CMP3) begin
                tm_cmp[sel - REG_CMP0] = data;
            end else if (sel >= REG_CMP_BUF0 && sel <= REG_CMP_BUF3) begin
                tm_cmp_buf[sel - REG_CMP_BUF0] = data;
                tm_buf_valid[sel - REG_CMP_BUF0] = 1'b1;
            end else if (sel == REG_LOCK_SET) begin
                tm_locked = 1'b1;
            end else if (sel == REG_LOCK_CLR) begin
                tm_locked = 1'b0;
            end else if (sel == REG_STATUS) begin
                tm_buf_valid = tm_buf_valid & ~data[STAT_PER_VLD_BIT:0];
                if (data[STAT_FAULT_BIT]) begin
                    tm_fault = 1'b0;
                end
            end else if (sel == REG_IRQ_FLAGS) begin
                if (data[0]) begin
                    tm_overflow = 1'b0;
                end
            end else if (sel == REG_COUNT) begin
                tm_count = data;
            end
        end else if (it.action == ACT_READ) begin
            if (sel == REG_PERIOD) begin
                rd = tm_period;
            end else if (sel == REG_PERIOD_BUF) begin
                rd = tm_period_buf;
            end else if (sel >= REG_CMP0 && sel <= REG_CMP3) begin
                rd = tm_cmp[sel - REG_CMP0];
            end else if (sel >= REG_CMP_BUF0 && sel <= REG_CMP_BUF3) begin
                rd = tm_cmp_buf[sel - REG_CMP_BUF0];
            end else if (sel == REG_LOCK_SET || sel == REG_LOCK_CLR) begin
                rd[0] = tm_locked;
            end else if (sel == REG_STATUS) begin
                rd[STAT_PER_VLD_BIT:0] = tm_buf_valid;
                rd[STAT_FAULT_BIT] = tm_fault;
            end else if (sel == REG_IRQ_FLAGS) begin
                rd[0] = tm_overflow;
            end else if (sel == REG_COUNT) begin
                rd = tm_count;
            end
        end

        // Output levels: disabled beats fault, fault beats compare.
        res.read_data = rd;
        res.pwm_out = '0;
        if (tm_cfg.enable && tm_fault) begin
            res.pwm_out = {CH_SLOTS{tm_cfg.fault_level}};
        end else if (tm_cfg.enable) begin
            for (ch = 0; ch < CH_SLOTS; ch++) begin
                res.pwm_out[ch] = (tm_count < tm_cmp[ch]) ^ tm_cfg.invert_mask[ch];
            end
        end
        res.irq = tm_overflow & tm_cfg.ovf_irq_en;
        res.fault_active = tm_fault;
        return res;
    endfunction

    task automatic flag_error(input string what, input logic [DATA_W-1:0] want,
                              input logic [DATA_W-1:0] got);
        mismatch_count++;
        if (mismatch_count <= 10) begin
            $display("%0t: %s: expected %0h, got %0h", $time, what, want, got);
        end
    endtask

    // Each result transfer is checked against the oldest prediction.
    always @(posedge clk) begin
        t_out_item want;
        if (rst_n && out_valid && out_ready) begin
            if (timer_outputs_due.size() == 0) begin
                flag_error("unexpected result, read_data", '0, out_item.read_data);
            end else begin
                want = timer_outputs_due.pop_front();
                if (out_item.read_data !== want.read_data) begin
                    flag_error("read_data", want.read_data, out_item.read_data);
                end
                if (out_item.pwm_out !== want.pwm_out) begin
                    flag_error("pwm_out", DATA_W'(want.pwm_out),
                               DATA_W'(out_item.pwm_out));
                end
                if (out_item.irq !== want.irq) begin
                    flag_error("irq", DATA_W'(want.irq), DATA_W'(out_item.irq));
                end
                if (out_item.fault_active !== want.fault_active) begin
                    flag_error("fault_active", DATA_W'(want.fault_active),
                               DATA_W'(out_item.fault_active));
                end
            end
        end
    end

    // Send one item, idling first at random; valid stays high for a follow-on.
    task automatic send_item(input t_in_item it);
        while ($urandom_range(99) < send_idle_pct) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_item <= it;
        do @(posedge clk); while (!in_ready);
        timer_outputs_due.push_back(advance_timer(it));
    endtask

    function automatic t_in_item make_item(input t_action act, input logic [SEL_W-1:0] sel,
                                           input logic [DATA_W-1:0] data, input logic fault_ev);
        t_in_item it;
        it.action = act;
        it.reg_select = sel;
        it.write_data = data;
        it.fault_event = fault_ev;
        return it;
    endfunction

    task automatic op_write(input logic [SEL_W-1:0] sel, input logic [DATA_W-1:0] data);
        send_item(make_item(ACT_WRITE, sel, data, 1'b0));
    endtask

    task automatic op_read(input logic [SEL_W-1:0] sel);
        send_item(make_item(ACT_READ, sel, '0, 1'b0));
    endtask

    task automatic op_tick(input logic fault_ev);
        send_item(make_item(ACT_TICK, '0, '0, fault_ev));
    endtask

    // Stop sending and wait until every owed result has been taken.
    task automatic wait_for_results();
        in_valid <= 1'b0;
        while (timer_outputs_due.size() != 0) begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic put_config_reg(input logic [CFG_IDX_W-1:0] idx,
                                  input logic [CFG_DATA_W-1:0] data);
        cfg_index <= idx;
        cfg_data <= data;
        do @(posedge clk); while (!cfg_ready);
    endtask

    // Write all five configuration registers back to back.
    task automatic write_config(input t_cfg c);
        cfg_valid <= 1'b1;
        put_config_reg(CFG_ENABLE, CFG_DATA_W'(c.enable));
        put_config_reg(CFG_INVERT_MASK, c.invert_mask);
        put_config_reg(CFG_FAULT_ENABLE, CFG_DATA_W'(c.fault_enable));
        put_config_reg(CFG_FAULT_LEVEL, CFG_DATA_W'(c.fault_level));
        put_config_reg(CFG_OVF_IRQ_EN, CFG_DATA_W'(c.ovf_irq_en));
        cfg_valid <= 1'b0;
        tm_cfg = c;
    endtask

    // Register values: mostly small so the counter turns around often.
    function automatic logic [DATA_W-1:0] random_value();
        int r;
        r = $urandom_range(99);
        if (r < 80) begin
            return DATA_W'($urandom_range(12));
        end else if (r < 92) begin
            return DATA_W'($urandom);
        end else if (r < 96) begin
            return '1;
        end
        return '0;
    endfunction

    function automatic t_in_item random_item();
        int r;
        logic [SEL_W-1:0] sel;
        sel = SEL_W'($urandom_range(15));
        r = $urandom_range(99);
        if (r < 55) begin
            return make_item(ACT_TICK, sel, DATA_W'($urandom), $urandom_range(99) < 4);
        end else if (r < 80) begin
            if (sel == REG_STATUS || sel == REG_IRQ_FLAGS) begin
                return make_item(ACT_WRITE, sel, DATA_W'($urandom), 1'($urandom));
            end
            return make_item(ACT_WRITE, sel, random_value(), 1'($urandom));
        end else if (r < 95) begin
            return make_item(ACT_READ, sel, DATA_W'($urandom), 1'($urandom));
        end
        return make_item(ACT_NONE, sel, DATA_W'($urandom), 1'($urandom));
    endfunction

    // Reset values, and a fault event taken while the counter is disabled.
    task automatic test_reset_values();
        op_read(REG_PERIOD);
        op_read(REG_STATUS);
        op_tick(1'b1);
        op_write(REG_STATUS, '1);
    endtask

    // Shortest up/down slope, with the buffer load held off by the lock.
    task automatic test_buffered_update();
        op_write(REG_PERIOD, 24'd1);
        op_write(REG_CMP0, 24'd1);
        op_write(REG_CMP_BUF0, '0);
        op_write(REG_PERIOD_BUF, 24'd2);
        op_write(REG_LOCK_SET, '0);
        op_tick(1'b0);
        op_tick(1'b0);
        op_write(REG_LOCK_CLR, '0);
        op_tick(1'b0);
        op_tick(1'b0);
    endtask

    // Count above the period, period zero, the unused selector and action.
    task automatic test_corner_cases();
        op_write(REG_COUNT, '1);
        op_tick(1'b0);
        op_write(REG_IRQ_FLAGS, 24'd1);
        op_write(REG_PERIOD, '0);
        op_write(REG_COUNT, '0);
        op_tick(1'b0);
        op_tick(1'b0);
        op_write(SEL_UNUSED, '1);
        op_read(SEL_UNUSED);
        send_item(make_item(ACT_NONE, REG_COUNT, '1, 1'b1));
        op_read(REG_COUNT);
    endtask

    // Extreme settings first, then random ones with the counter mostly enabled.
    function automatic t_cfg pick_config(input int seg);
        case (seg)
            0: return '{1'b1, 4'h0, 1'b1, 1'b0, 1'b1};
            1: return '{1'b1, 4'hF, 1'b1, 1'b1, 1'b0};
            2: return '{1'b0, 4'h5, 1'b1, 1'b1, 1'b1};
            3: return '{1'b1, 4'hA, 1'b0, 1'b0, 1'b1};
            default: return '{$urandom_range(4) != 0, 4'($urandom), 1'($urandom),
                               1'($urandom), 1'($urandom)};
        endcase
    endfunction

    // One segment of random traffic under a given setting and idling mix.
    task automatic test_random_traffic(input int seg);
        wait_for_results();
        write_config(pick_config(seg));
        case (seg / 2)
            0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_idle_pct = 59; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 59; end
            default: begin send_idle_pct = 18; recv_stall_pct = 18; end
        endcase
        repeat (SEGMENT_ITEMS) send_item(random_item());
    endtask

    initial begin
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_reset_values();
        wait_for_results();
        write_config('{1'b1, 4'h0, 1'b1, 1'b0, 1'b1});
        test_buffered_update();
        test_corner_cases();
        for (int seg = 0; seg < NUM_SEGMENTS; seg++) begin
            test_random_traffic(seg);
        end
        wait_for_results();
        if (mismatch_count == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

    // Watchdog on the whole run.
    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge clk);
        end
        $display("Verification failed");
        $finish;
    end

endmodule
